@@ hdl/icmper_pkg.sv @@
`timescale 1ns / 1ps

package icmper_pkg;

   typedef enum logic [1:0] {
      ACT_BYTE = 2'd0,
      ACT_TICK = 2'd1,
      ACT_SENT = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      VERDICT_DROP   = 2'd0,
      VERDICT_REPLY  = 2'd1,
      VERDICT_MATCH  = 2'd2,
      VERDICT_IGNORE = 2'd3
   } verdict_type;

   typedef enum logic {
      KIND_VERDICT = 1'b0,
      KIND_REQUEST = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_PING_ACTIVE = 1'b0,
      CSR_PING_ID     = 1'b1
   } csr_index_type;

   localparam logic [7:0]  TYPE_ECHO_REPLY   = 8'd0;
   localparam logic [7:0]  TYPE_ECHO_REQUEST = 8'd8;
   localparam logic [15:0] REQUEST_TYPE_CODE = {TYPE_ECHO_REQUEST, 8'h00};
   localparam logic [15:0] SUM_GOOD          = 16'hFFFF;
   localparam int          MIN_MSG_BYTES     = 8;

   typedef struct packed {
      kind_type    kind;
      verdict_type verdict;
      logic [15:0] checksum;
      logic [31:0] rtt_ticks;
      logic [31:0] sent_count;
      logic [31:0] reply_count;
      logic        reply_flag;
   } result_type;

   // one's-complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // folded sum of the request payload pattern (byte i holds i & 0xFF);
   // only evaluated at elaboration
   function automatic logic [15:0] pattern_sum(input int n_bytes);
      logic [15:0] s;
      logic [7:0]  hi;
      logic [7:0]  lo;
      s = 16'd0;
      for (int i = 0; i < n_bytes; i += 2) begin
         hi = 8'(i);
         lo = (i + 1 < n_bytes) ? 8'(i + 1) : 8'd0;
         s  = oc_add(s, {hi, lo});
      end
      return s;
   endfunction

endpackage

@@ hdl/icmp_echo_responder.sv @@
`timescale 1ns / 1ps

// ICMP echo responder and ping tracker.
// req_ channel: one transaction per cycle at most. action selects a message
// byte (data_byte, last_byte), a timer tick, or an "echo request sent" event
// (echo_id, echo_seq). Message bytes build the one's-complement sum and the
// header fields; the last byte yields a verdict transaction on rsp_.
// A sent event yields a request checksum transaction; ticks yield nothing.
// rsp_ channel: each result is registered in the output register (or the skid
// register while that one waits), carrying the status counters after that step.
// Throughput is one transaction per cycle while req_ready is high: all per-item
// work is a single combinational pass (three chained 16-bit end-around adds)
// into the state and output registers. A skid register behind the output
// register lets req_ keep accepting while one result waits; req_ready drops
// only while both are full, and a stalled rsp_ holds its payload.
// csr_ writes (index 0 ping_active, 1 ping_id) take effect at the next edge.
// reset (synchronous) clears all counters, the message state, the session
// registers and both result slots.
module icmp_echo_responder #(
   parameter int MTU_BYTES     = 1500,
   parameter int PATTERN_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [15:0] req_echo_id,
   input  logic [15:0] req_echo_seq,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [1:0]  rsp_verdict,
   output logic [15:0] rsp_checksum_out,
   output logic [31:0] rsp_rtt_ticks,
   output logic [31:0] rsp_sent_count,
   output logic [31:0] rsp_reply_count,
   output logic        rsp_reply_flag,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data
);
   import icmper_pkg::*;

   // byte counter saturates at MTU_BYTES + 1
   localparam int              CNT_W   = $clog2(MTU_BYTES + 2);
   localparam logic [CNT_W-1:0] MTU_CNT = CNT_W'(MTU_BYTES);
   localparam logic [CNT_W-1:0] OVR_CNT = CNT_W'(MTU_BYTES + 1);
   localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_MSG_BYTES);
   localparam logic [15:0]      PAT_SUM = pattern_sum(PATTERN_BYTES);

   // session registers
   logic        ping_active_ff;
   logic [15:0] ping_id_ff;

   // per-message state
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0]  pending_high_ff, pending_high_in;
   logic [7:0]  msg_type_ff, msg_type_in;
   logic [7:0]  msg_code_ff, msg_code_in;
   logic [15:0] msg_checksum_ff, msg_checksum_in;
   logic [15:0] msg_ident_ff, msg_ident_in;

   // ping tracking
   logic [31:0] tick_count_ff, tick_count_in;
   logic [31:0] send_stamp_ff, send_stamp_in;
   logic [31:0] sent_total_ff, sent_total_in;
   logic [31:0] reply_total_ff, reply_total_in;
   logic [31:0] last_rtt_ff, last_rtt_in;
   logic        reply_seen_ff, reply_seen_in;

   // result slots: output register plus skid
   logic       out_valid_ff;
   logic       skid_valid_ff;
   result_type out_ff;
   result_type skid_ff;

   logic        req_fire;
   logic        rsp_fire;
   logic        push;
   result_type  new_rsp;
   logic [15:0] msg_total;
   logic [15:0] req_sum;
   action_type  action;
   verdict_type verdict;

   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = out_valid_ff && rsp_ready;
   assign action    = action_type'(req_action);

   // request checksum: header 0x0800, id, seq, then the pattern folded up front
   assign req_sum = oc_add(oc_add(oc_add(REQUEST_TYPE_CODE, req_echo_id), req_echo_seq),
                           PAT_SUM);

   always_comb begin
      byte_count_in   = byte_count_ff;
      running_sum_in  = running_sum_ff;
      pending_high_in = pending_high_ff;
      msg_type_in     = msg_type_ff;
      msg_code_in     = msg_code_ff;
      msg_checksum_in = msg_checksum_ff;
      msg_ident_in    = msg_ident_ff;
      tick_count_in   = tick_count_ff;
      send_stamp_in   = send_stamp_ff;
      sent_total_in   = sent_total_ff;
      reply_total_in  = reply_total_ff;
      last_rtt_in     = last_rtt_ff;
      reply_seen_in   = reply_seen_ff;
      push            = 1'b0;
      verdict         = VERDICT_IGNORE;
      msg_total       = 16'd0;
      new_rsp         = '0;

      if (req_fire) begin
         unique case (action)
            ACT_BYTE: begin
               if (byte_count_ff < MTU_CNT) begin
                  if (byte_count_ff == CNT_W'(0)) msg_type_in = req_data_byte;
                  else if (byte_count_ff == CNT_W'(1)) msg_code_in = req_data_byte;
                  else if (byte_count_ff == CNT_W'(2))
                     msg_checksum_in = {req_data_byte, 8'h00};
                  else if (byte_count_ff == CNT_W'(3))
                     msg_checksum_in = {msg_checksum_ff[15:8], req_data_byte};
                  else if (byte_count_ff == CNT_W'(4))
                     msg_ident_in = {req_data_byte, 8'h00};
                  else if (byte_count_ff == CNT_W'(5))
                     msg_ident_in = {msg_ident_ff[15:8], req_data_byte};

                  // words from byte 4 on; an odd last byte is zero padded
                  if (!byte_count_ff[0]) begin
                     pending_high_in = req_data_byte;
                     if (byte_count_ff >= CNT_W'(4) && req_last_byte)
                        running_sum_in = oc_add(running_sum_ff, {req_data_byte, 8'h00});
                  end else if (byte_count_ff >= CNT_W'(4)) begin
                     running_sum_in = oc_add(running_sum_ff, {pending_high_ff, req_data_byte});
                  end
                  byte_count_in = byte_count_ff + CNT_W'(1);
               end else begin
                  byte_count_in = OVR_CNT;
               end

               if (req_last_byte) begin
                  msg_total = oc_add(oc_add(running_sum_in, {msg_type_in, msg_code_in}),
                                     msg_checksum_in);
                  new_rsp.checksum = 16'd0;
                  if (byte_count_in < MIN_CNT || byte_count_in > MTU_CNT
                      || msg_total != SUM_GOOD) begin
                     verdict = VERDICT_DROP;
                  end else if (msg_type_in == TYPE_ECHO_REQUEST) begin
                     // reply differs only in the type byte, which is outside running_sum
                     verdict = VERDICT_REPLY;
                     new_rsp.checksum = ~running_sum_in;
                  end else if (msg_type_in == TYPE_ECHO_REPLY && ping_active_ff
                               && msg_ident_in == ping_id_ff) begin
                     verdict        = VERDICT_MATCH;
                     reply_total_in = reply_total_ff + 32'd1;
                     last_rtt_in    = tick_count_ff - send_stamp_ff;
                     reply_seen_in  = 1'b1;
                  end else begin
                     verdict = VERDICT_IGNORE;
                  end
                  push            = 1'b1;
                  new_rsp.kind    = KIND_VERDICT;
                  new_rsp.verdict = verdict;
                  // message done: start the next one clean
                  byte_count_in   = '0;
                  running_sum_in  = 16'd0;
                  pending_high_in = 8'd0;
                  msg_type_in     = 8'd0;
                  msg_code_in     = 8'd0;
                  msg_checksum_in = 16'd0;
                  msg_ident_in    = 16'd0;
               end
            end
            ACT_TICK: begin
               tick_count_in = tick_count_ff + 32'd1;
            end
            ACT_SENT: begin
               send_stamp_in    = tick_count_ff;
               sent_total_in    = sent_total_ff + 32'd1;
               push             = 1'b1;
               new_rsp.kind     = KIND_REQUEST;
               new_rsp.verdict  = VERDICT_DROP;
               new_rsp.checksum = ~req_sum;
            end
            ACT_NONE: begin
            end
            default: begin
            end
         endcase
      end

      new_rsp.rtt_ticks   = last_rtt_in;
      new_rsp.sent_count  = sent_total_in;
      new_rsp.reply_count = reply_total_in;
      new_rsp.reply_flag  = reply_seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ping_active_ff  <= 1'b0;
         ping_id_ff      <= 16'd0;
         byte_count_ff   <= '0;
         running_sum_ff  <= 16'd0;
         pending_high_ff <= 8'd0;
         msg_type_ff     <= 8'd0;
         msg_code_ff     <= 8'd0;
         msg_checksum_ff <= 16'd0;
         msg_ident_ff    <= 16'd0;
         tick_count_ff   <= 32'd0;
         send_stamp_ff   <= 32'd0;
         sent_total_ff   <= 32'd0;
         reply_total_ff  <= 32'd0;
         last_rtt_ff     <= 32'd0;
         reply_seen_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_PING_ACTIVE: ping_active_ff <= csr_write_data[0];
               CSR_PING_ID:     ping_id_ff     <= csr_write_data;
               default: begin
               end
            endcase
         end
         byte_count_ff   <= byte_count_in;
         running_sum_ff  <= running_sum_in;
         pending_high_ff <= pending_high_in;
         msg_type_ff     <= msg_type_in;
         msg_code_ff     <= msg_code_in;
         msg_checksum_ff <= msg_checksum_in;
         msg_ident_ff    <= msg_ident_in;
         tick_count_ff   <= tick_count_in;
         send_stamp_ff   <= send_stamp_in;
         sent_total_ff   <= sent_total_in;
         reply_total_ff  <= reply_total_in;
         last_rtt_ff     <= last_rtt_in;
         reply_seen_ff   <= reply_seen_in;
      end
   end

   // output register and skid; no push happens while skid is full
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || rsp_fire) begin
            out_ff       <= new_rsp;
            out_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= new_rsp;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_verdict      = out_ff.verdict;
   assign rsp_checksum_out = out_ff.checksum;
   assign rsp_rtt_ticks    = out_ff.rtt_ticks;
   assign rsp_sent_count   = out_ff.sent_count;
   assign rsp_reply_count  = out_ff.reply_count;
   assign rsp_reply_flag   = out_ff.reply_flag;

endmodule
